// ----- src/utf8d_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared item types, status codes and sizes for the UTF-8 to UTF-32 decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_NULL        = 3'd1;
   localparam logic [2:0] STATUS_SURROGATE   = 3'd2;
   localparam logic [2:0] STATUS_RANGE       = 3'd3;
   localparam logic [2:0] STATUS_STRAY       = 3'd4;
   localparam logic [2:0] STATUS_INTERRUPTED = 3'd5;
   localparam logic [2:0] STATUS_TRUNCATED   = 3'd6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [31:0] codepoint;
      logic [2:0]  status;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic [31:0] codepoint;
      logic [2:0]  status;
   } result_type;

   // One queue entry holds every result that one input item causes.
   typedef struct packed {
      result_type first;
      result_type second;
      logic       two;
   } entry_type;

endpackage

// ----- src/utf8d_front.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts bytes, tracks the pending sequence and forms the results of each item.
// ----------------------------------------------------------------------------
module utf8d_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  utf8d_pkg::req_type   req_data,
   input  logic                 csr_write_enable,
   input  logic                 csr_write_data,
   output logic                 entry_push,
   output utf8d_pkg::entry_type entry_data
);

   logic        allow_extended_ff, allow_extended_in;
   logic [31:0] partial_ff, partial_in;
   logic [2:0]  left_ff, left_in;

   logic [7:0]  b;
   logic        eoi;
   logic        is_cont;
   logic [5:0]  cont_shift;
   logic [31:0] merged;
   logic [2:0]  merged_left;

   logic        lead_emit;
   utf8d_pkg::result_type lead_res;
   logic [31:0] lead_partial;
   logic [2:0]  lead_left;
   logic [31:0] lead_bits;
   logic [5:0]  lead_shift;
   logic [31:0] lead_init;

   utf8d_pkg::result_type res_a;
   utf8d_pkg::result_type res_b;
   logic [1:0]  res_count;

   function automatic logic [2:0] classify(input logic [31:0] cp);
      priority if (cp == 32'd0) begin
         classify = utf8d_pkg::STATUS_NULL;
      end else if ((cp & 32'h0000_F800) == 32'h0000_D800) begin
         classify = utf8d_pkg::STATUS_SURROGATE;
      end else if (cp >= 32'h0011_0000) begin
         classify = utf8d_pkg::STATUS_RANGE;
      end else begin
         classify = utf8d_pkg::STATUS_OK;
      end
   endfunction

   assign b       = req_data.data_byte;
   assign eoi     = req_data.end_of_input;
   assign is_cont = (b[7:6] == 2'b10);

   always_comb begin
      unique case (left_ff)
         3'd2:    cont_shift = 6'd6;
         3'd3:    cont_shift = 6'd12;
         3'd4:    cont_shift = 6'd18;
         3'd5:    cont_shift = 6'd24;
         3'd6:    cont_shift = 6'd30;
         3'd7:    cont_shift = 6'd36;
         default: cont_shift = 6'd0;
      endcase
      merged      = partial_ff | (32'(b[5:0]) << cont_shift);
      merged_left = left_ff - 3'd1;
   end

   // Lead byte decode, as if no sequence were pending.
   always_comb begin
      lead_emit    = 1'b0;
      lead_res     = '{codepoint: 32'(b), status: utf8d_pkg::STATUS_STRAY};
      lead_partial = 32'd0;
      lead_left    = 3'd0;
      lead_bits    = 32'd0;
      lead_shift   = 6'd0;
      priority if (b < 8'hE0) begin
         lead_bits = 32'(b[4:0]); lead_shift = 6'd6;  lead_left = 3'd1;
      end else if (b < 8'hF0) begin
         lead_bits = 32'(b[3:0]); lead_shift = 6'd12; lead_left = 3'd2;
      end else if (b < 8'hF8) begin
         lead_bits = 32'(b[2:0]); lead_shift = 6'd18; lead_left = 3'd3;
      end else if (b < 8'hFC) begin
         lead_bits = 32'(b[1:0]); lead_shift = 6'd24; lead_left = 3'd4;
      end else if (b < 8'hFE) begin
         lead_bits = 32'(b[0]);   lead_shift = 6'd30; lead_left = 3'd5;
      end else begin
         lead_bits = 32'd0;       lead_shift = 6'd36; lead_left = 3'd6;
      end
      lead_init = lead_bits << lead_shift;
      priority if (b < 8'h80) begin
         lead_emit = 1'b1;
         lead_left = 3'd0;
         lead_res.status = (b == 8'h00) ? utf8d_pkg::STATUS_NULL : utf8d_pkg::STATUS_OK;
      end else if (b < 8'hC0 || b == 8'hFF || (b >= 8'hF5 && !allow_extended_ff)) begin
         lead_emit = 1'b1;
         lead_left = 3'd0;
      end else if (eoi) begin
         lead_emit = 1'b1;
         lead_left = 3'd0;
         lead_res  = '{codepoint: lead_init, status: utf8d_pkg::STATUS_TRUNCATED};
      end else begin
         lead_partial = lead_init;
      end
   end

   always_comb begin
      res_a      = '{codepoint: merged, status: classify(merged)};
      res_b      = lead_res;
      res_count  = 2'd0;
      partial_in = partial_ff;
      left_in    = left_ff;
      if (left_ff != 3'd0 && is_cont) begin
         if (merged_left == 3'd0) begin
            res_count  = 2'd1;
            partial_in = 32'd0;
            left_in    = 3'd0;
         end else if (eoi) begin
            res_a      = '{codepoint: merged, status: utf8d_pkg::STATUS_TRUNCATED};
            res_count  = 2'd1;
            partial_in = 32'd0;
            left_in    = 3'd0;
         end else begin
            partial_in = merged;
            left_in    = merged_left;
         end
      end else begin
         partial_in = lead_partial;
         left_in    = lead_left;
         if (left_ff != 3'd0) begin
            res_a     = '{codepoint: partial_ff, status: utf8d_pkg::STATUS_INTERRUPTED};
            res_count = lead_emit ? 2'd2 : 2'd1;
         end else begin
            res_a     = lead_res;
            res_count = lead_emit ? 2'd1 : 2'd0;
         end
      end
      if (!accept) begin
         partial_in = partial_ff;
         left_in    = left_ff;
      end
      allow_extended_in = csr_write_enable ? csr_write_data : allow_extended_ff;
   end

   assign entry_push = accept && (res_count != 2'd0);
   assign entry_data = '{first: res_a, second: res_b, two: (res_count == 2'd2)};

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_extended_ff <= 1'b0;
         partial_ff        <= 32'd0;
         left_ff           <= 3'd0;
      end else begin
         allow_extended_ff <= allow_extended_in;
         partial_ff        <= partial_in;
         left_ff           <= left_in;
      end
   end

endmodule

// ----- src/utf8d_queue.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder entry queue
// A short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module utf8d_queue #(
   parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  utf8d_pkg::entry_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output utf8d_pkg::entry_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   utf8d_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/utf8d_back.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Splits queue entries into single results and holds them in the output register.
// ----------------------------------------------------------------------------
module utf8d_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  utf8d_pkg::entry_type q_head,
   output logic                 q_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output utf8d_pkg::rsp_type   rsp_data
);

   logic               valid_ff, valid_in;
   logic               second_ff, second_in;
   utf8d_pkg::rsp_type out_ff, out_in;
   logic               load;

   assign load = !valid_ff || rsp_pop;

   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      out_in    = out_ff;
      q_pop     = 1'b0;
      if (load) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            if (second_ff) begin
               out_in    = '{codepoint: q_head.second.codepoint,
                             status: q_head.second.status, last_result: 1'b1};
               second_in = 1'b0;
               q_pop     = 1'b1;
            end else begin
               out_in    = '{codepoint: q_head.first.codepoint,
                             status: q_head.first.status, last_result: !q_head.two};
               second_in = q_head.two;
               q_pop     = !q_head.two;
            end
         end
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

// ----- src/utf8_to_utf32_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-32 decoder unit
// Decodes a UTF-8 byte stream into codepoints with a status for each result.
// ----------------------------------------------------------------------------
//  Port group   Direction  Handshake              Payload
//  req_         in         push / full            data_byte, end_of_input
//  rsp_         out        empty / pop            codepoint, status, last_result
//  csr_         in         write enable           allow_extended
//
//  A byte is taken every cycle while the entry queue has room.
//  Each result is held in the output register on its own, so a byte that causes
//  two results occupies the output side with two separate results in turn.
//  A result passes through the entry queue and then the output register before it reaches the ports.
//  Reset clears the pending sequence, the queue and the output register's valid flag.
//  A stalled output fills the queue, which then raises full.
// ----------------------------------------------------------------------------
module utf8_to_utf32_decoder_unit #(
   parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  utf8d_pkg::req_type req_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output utf8d_pkg::rsp_type rsp_data,
   input  logic               csr_write_enable,
   input  logic               csr_write_data
);

   logic                 accept;
   logic                 entry_push;
   utf8d_pkg::entry_type entry_data;
   logic                 q_empty;
   logic                 q_pop;
   utf8d_pkg::entry_type q_head;

   assign accept = req_push && !req_full;

   utf8d_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .entry_push       (entry_push),
      .entry_data       (entry_data)
   );

   utf8d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (entry_push),
      .push_data (entry_data),
      .full      (req_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   utf8d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- src/utf8d_checker.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder checker
// Port-level assertions for the decoder unit, attached by a bind statement.
// ----------------------------------------------------------------------------
module utf8d_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input utf8d_pkg::rsp_type rsp_data
);

   a_reset_empty : assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result side not empty after reset");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled item changed or vanished");

   a_null_zero : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status == utf8d_pkg::STATUS_NULL)
         |-> (rsp_data.codepoint == 32'd0))
      else $error("null status with a non-zero codepoint");

   a_stray_byte : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status == utf8d_pkg::STATUS_STRAY)
         |-> (rsp_data.codepoint[31:8] == 24'd0))
      else $error("stray byte result wider than a byte");

   a_surrogate : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status == utf8d_pkg::STATUS_SURROGATE)
         |-> (rsp_data.codepoint[15:11] == 5'b11011))
      else $error("surrogate status outside the surrogate range");

endmodule

bind utf8_to_utf32_decoder_unit utf8d_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
